/* rtl/psm_pkg.sv */
// shared types and constants for the prime spiral cell mapper
package psm_pkg;

  localparam int MAX_SIZE    = 127;
  localparam int SIEVE_DEPTH = 16384;
  localparam int START_LIMIT = 50;

  localparam int MAP_AW = $clog2(SIEVE_DEPTH);
  localparam int I_W    = MAP_AW / 2 + 2;
  localparam int SQ_W   = 2 * I_W;

  localparam int SIZE_W  = 7;
  localparam int START_W = 8;
  localparam int COORD_W = 7;
  localparam int NUM_W   = 14;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 8;

  typedef enum logic [CFG_IW-1:0] {
    REG_SPIRAL_SIZE = 2'd0,
    REG_START_VALUE = 2'd1
  } psm_reg_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_START  = 2'd1,
    STAT_EVEN_SIZE  = 2'd2,
    STAT_OUTSIDE    = 2'd3
  } psm_status_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } psm_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] cell_number;
    logic             is_prime;
    psm_status_t      status;
  } psm_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic              wr_data;
  } psm_mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIEVE,
    ST_CALC,
    ST_READ,
    ST_DONE
  } psm_state_t;

  typedef enum logic [2:0] {
    SV_IDLE,
    SV_INIT,
    SV_RD,
    SV_CHK,
    SV_MARK
  } psm_sieve_state_t;

endpackage

/* rtl/psm_ram.sv */
// generic single-write, single-read ram with registered read
module psm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/psm_sieve.sv */
// sieve of eratosthenes sequencer over the prime bit map
module psm_sieve (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [psm_pkg::MAP_AW-1:0] lim,
  input  logic                      rd_data,
  output psm_pkg::psm_mem_req_t     mem_req,
  output logic                      busy,
  output logic                      done
);
  import psm_pkg::*;

  psm_sieve_state_t  state_r, state_nxt;
  logic [I_W-1:0]    i_r, i_nxt;
  logic [MAP_AW:0]   j_r, j_nxt;
  logic [SQ_W-1:0]   sq;
  logic              sq_over;
  logic [MAP_AW:0]   j_step;
  logic              j_over;
  logic              init_last;

  assign sq        = SQ_W'(i_r) * SQ_W'(i_r);
  assign sq_over   = sq > SQ_W'(lim);
  assign j_step    = j_r + (MAP_AW + 1)'(i_r);
  assign j_over    = j_step > {1'b0, lim};
  assign init_last = j_r[MAP_AW-1:0] == lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SV_IDLE: if (start) state_nxt = SV_INIT;
      SV_INIT: if (init_last) state_nxt = SV_RD;
      SV_RD:   state_nxt = sq_over ? SV_IDLE : SV_CHK;
      SV_CHK:  state_nxt = rd_data ? SV_MARK : SV_RD;
      SV_MARK: if (j_over) state_nxt = SV_RD;
      default: state_nxt = SV_IDLE;
    endcase
  end

  // counters
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    unique case (state_r)
      SV_IDLE: begin
        i_nxt = I_W'(2);
        j_nxt = '0;
      end
      SV_INIT: j_nxt = j_r + 1'b1;
      SV_RD:   j_nxt = (MAP_AW + 1)'(sq);
      SV_CHK:  if (!rd_data) i_nxt = i_r + 1'b1;
      SV_MARK: begin
        j_nxt = j_step;
        if (j_over) i_nxt = i_r + 1'b1;
      end
      default: begin
        i_nxt = i_r;
        j_nxt = j_r;
      end
    endcase
  end

  // outputs
  always_comb begin
    mem_req = '0;
    busy    = state_r != SV_IDLE;
    done    = 1'b0;
    unique case (state_r)
      SV_IDLE: ;
      SV_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = j_r[MAP_AW-1:0];
        mem_req.wr_data = j_r >= (MAP_AW + 1)'(2);
      end
      SV_RD: begin
        mem_req.rd_en   = !sq_over;
        mem_req.rd_addr = MAP_AW'(i_r);
        done            = sq_over;
      end
      SV_CHK: ;
      SV_MARK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = j_r[MAP_AW-1:0];
        mem_req.wr_data = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/psm_spiral.sv */
// closed-form spiral placement, two register stages
module psm_spiral (
  input  logic                        clk,
  input  logic                        load,
  input  logic [psm_pkg::SIZE_W-1:0]  size,
  input  logic [psm_pkg::START_W-1:0] start_value,
  input  logic [psm_pkg::COORD_W-1:0] row,
  input  logic [psm_pkg::COORD_W-1:0] col,
  output logic [psm_pkg::NUM_W-1:0]   num
);
  import psm_pkg::*;

  logic [SIZE_W-2:0]  c;
  logic signed [8:0]  dx, dy;
  logic [7:0]         ax, ay;
  logic signed [8:0]  dx_r, dy_r;
  logic [7:0]         k_r;
  logic [7:0]         tw;
  logic [15:0]        base;
  logic signed [11:0] ks, term;
  logic signed [17:0] sum;
  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   num_nxt_w;

  // stage 1: offsets from the centre and ring index
  assign c  = size[SIZE_W-1:1];
  assign dx = $signed({2'b00, col}) - $signed({3'b000, c});
  assign dy = $signed({3'b000, c}) - $signed({2'b00, row});
  assign ax = dx[8] ? 8'(-dx) : 8'(dx);
  assign ay = dy[8] ? 8'(-dy) : 8'(dy);

  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= dx;
      dy_r <= dy;
      k_r  <= (ax > ay) ? ax : ay;
    end
    num_r <= num_nxt_w;
  end

  // stage 2: inner square area plus position along the ring
  assign tw   = (k_r << 1) - 8'd1;
  assign base = 16'(tw) * 16'(tw);
  assign ks   = $signed({4'b0000, k_r});

  always_comb begin
    priority if (k_r == '0) begin
      term = '0;
    end else if (12'(dx_r) == ks && 12'(dy_r) > -ks) begin
      term = 12'(dy_r) + ks - 12'sd1;
    end else if (12'(dy_r) == ks) begin
      term = 12'sd3 * ks - 12'sd1 - 12'(dx_r);
    end else if (12'(dx_r) == -ks) begin
      term = 12'sd5 * ks - 12'sd1 - 12'(dy_r);
    end else begin
      term = 12'sd7 * ks - 12'sd1 + 12'(dx_r);
    end
  end

  assign sum = (k_r == '0) ? $signed({10'b0, start_value})
             : $signed({2'b00, base}) + 18'(term) + $signed({10'b0, start_value});
  assign num_nxt_w = sum[NUM_W-1:0];
  assign num       = num_r;

endmodule

/* rtl/prime_spiral_cell_mapper_unit.sv */
// top level of the prime spiral cell mapper
//
// takes a (row, col) word and returns the number an anticlockwise spiral
// places at that cell of an odd spiral_size square, centred on start_value,
// together with a primality flag and a status code. one result word per
// request word. the first request with good start and size after reset or
// after a write to a known register runs a sieve of eratosthenes into a
// 1-bit prime map held in a 16384-entry ram, over 0 to size^2 + start - 1;
// this pass writes each map entry from 0 to lim, then reads each candidate
// up to sqrt(lim) and crosses off its multiples from its square. the map
// is not cleared at reset: the sieve writes every entry it later reads.
// once the map is built a good request goes through accept, placement
// arithmetic, map read and result load; a request rejected for bad start,
// even size or an outside cell on a built map goes straight to result load.
// requests are handled one at a time; the result register lets a finished
// word wait on out_ready while the next request is accepted. register
// writes go through cfg_* and must only be made while the block is idle.
module prime_spiral_cell_mapper_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  psm_pkg::psm_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output psm_pkg::psm_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [psm_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [psm_pkg::CFG_DW-1:0]  cfg_data
);
  import psm_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]  size_r;
  logic [START_W-1:0] start_r;
  logic               sieve_ready_r;
  logic [MAP_AW-1:0]  lim_r, lim_nxt;
  logic [15:0]        lim_full;
  logic               cfg_fire;
  logic               cfg_known;

  // request control
  psm_state_t   state_r, state_nxt;
  psm_status_t  status_r, status_nxt;
  logic         in_fire;
  logic         bad_start, bad_size, outside;
  logic         sieve_start, sieve_busy, sieve_done;
  psm_mem_req_t sieve_req;

  // map port
  logic              map_rd_en;
  logic [MAP_AW-1:0] map_rd_addr;
  logic              map_rd_data;

  // placement and result
  logic [NUM_W-1:0] num;
  logic             out_valid_r, out_valid_nxt;
  psm_out_t         out_data_r, out_data_nxt;
  logic             out_load;
  logic             num_in_map;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == REG_SPIRAL_SIZE) || (cfg_index == REG_START_VALUE);

  // sieve upper bound, clipped to the map depth
  assign lim_full = 16'(size_r) * 16'(size_r) + 16'(start_r) - 16'd1;
  assign lim_nxt  = (32'(lim_full) > SIEVE_DEPTH - 1) ? MAP_AW'(SIEVE_DEPTH - 1)
                                                      : MAP_AW'(lim_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r        <= SIZE_W'(1);
      start_r       <= START_W'(1);
      sieve_ready_r <= 1'b0;
    end else begin
      if (cfg_fire && cfg_index == REG_SPIRAL_SIZE) begin
        size_r <= cfg_data[SIZE_W-1:0];
      end
      if (cfg_fire && cfg_index == REG_START_VALUE) begin
        start_r <= cfg_data[START_W-1:0];
      end
      // a write to a known register invalidates the map
      if (cfg_fire && cfg_known) begin
        sieve_ready_r <= 1'b0;
      end else if (sieve_done) begin
        sieve_ready_r <= 1'b1;
      end
    end
    lim_r <= lim_nxt;
  end

  // request checks, start value has priority over size
  assign in_fire   = in_valid && in_ready;
  assign bad_start = (start_r == '0) || (32'(start_r) > START_LIMIT);
  assign bad_size  = !size_r[0] || (32'(size_r) > MAX_SIZE);
  assign outside   = (in_data.row >= size_r) || (in_data.col >= size_r);

  always_comb begin
    priority if (bad_start) begin
      status_nxt = STAT_BAD_START;
    end else if (bad_size) begin
      status_nxt = STAT_EVEN_SIZE;
    end else if (outside) begin
      status_nxt = STAT_OUTSIDE;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (status_nxt == STAT_BAD_START || status_nxt == STAT_EVEN_SIZE) begin
            state_nxt = ST_DONE;
          end else if (!sieve_ready_r) begin
            state_nxt = ST_SIEVE;
          end else if (status_nxt == STAT_OUTSIDE) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_SIEVE: begin
        if (sieve_done) begin
          state_nxt = (status_r == STAT_OUTSIDE) ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the request sequencer
  always_comb begin
    in_ready    = 1'b0;
    sieve_start = 1'b0;
    map_rd_en   = sieve_req.rd_en;
    map_rd_addr = sieve_req.rd_addr;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        sieve_start = in_fire && !sieve_ready_r && !bad_start && !bad_size;
      end
      ST_SIEVE: ;
      ST_CALC:  ;
      ST_READ: begin
        map_rd_en   = 1'b1;
        map_rd_addr = MAP_AW'(num);
      end
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  // result word, zero fields unless the cell was placed
  assign num_in_map = 32'(num) < SIEVE_DEPTH;

  always_comb begin
    out_data_nxt.status      = status_r;
    out_data_nxt.cell_number = (status_r == STAT_OK) ? num : '0;
    out_data_nxt.is_prime    = (status_r == STAT_OK) && num_in_map && map_rd_data;
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  psm_spiral u_spiral (
    .clk         (clk),
    .load        (in_fire),
    .size        (size_r),
    .start_value (start_r),
    .row         (in_data.row),
    .col         (in_data.col),
    .num         (num)
  );

  psm_sieve u_sieve (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sieve_start),
    .lim     (lim_r),
    .rd_data (map_rd_data),
    .mem_req (sieve_req),
    .busy    (sieve_busy),
    .done    (sieve_done)
  );

  psm_ram #(
    .WIDTH (1),
    .DEPTH (SIEVE_DEPTH)
  ) u_prime_map (
    .clk     (clk),
    .wr_en   (sieve_req.wr_en),
    .wr_addr (sieve_req.wr_addr),
    .wr_data (sieve_req.wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  // sieve only runs while a request waits on it
  a_sieve_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sieve_busy |-> state_r == ST_SIEVE)
    else $error("sieve busy outside sieve wait");

  // a new sieve pass only starts on a stale map
  a_sieve_stale: assert property (@(posedge clk) disable iff (!rst_n)
    sieve_start |-> !sieve_ready_r)
    else $error("sieve restarted on a ready map");

  // error results carry no number and no prime flag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK)
      |-> (out_data.cell_number == '0 && !out_data.is_prime))
    else $error("error result with nonzero payload");

  // a finished sieve leaves the map marked ready
  a_sieve_mark: assert property (@(posedge clk) disable iff (!rst_n)
    sieve_done |=> sieve_ready_r)
    else $error("map not marked ready after sieve");

endmodule
